// ===== src/rvex_pkg.sv =====
`default_nettype none
package rvex_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_AW = $clog2(REG_COUNT);

  typedef enum logic [6:0] {
    OPC_LUI    = 7'h37,
    OPC_AUIPC  = 7'h17,
    OPC_JAL    = 7'h6F,
    OPC_JALR   = 7'h67,
    OPC_BRANCH = 7'h63,
    OPC_LOAD   = 7'h03,
    OPC_STORE  = 7'h23,
    OPC_OPIMM  = 7'h13,
    OPC_OP     = 7'h33,
    OPC_SYSTEM = 7'h73
  } opcode_e;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_LOAD  = 2'd1,
    MEM_STORE = 2'd2
  } mem_op_e;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } mem_size_e;

  typedef enum logic [1:0] {
    ENV_NONE   = 2'd0,
    ENV_ECALL  = 2'd1,
    ENV_EBREAK = 2'd2
  } env_e;

  typedef enum logic [0:0] {
    CMD_EXEC = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_e;

  localparam logic [2:0] LD_B  = 3'd0;
  localparam logic [2:0] LD_H  = 3'd1;
  localparam logic [2:0] LD_BU = 3'd4;
  localparam logic [2:0] LD_HU = 3'd5;

  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [1:0]  mem_op;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
    logic [1:0]  mem_size;
    logic        wb_valid;
    logic [4:0]  wb_index;
    logic [31:0] wb_value;
    logic        trap;
    logic [1:0]  env_call;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [4:0] dest;
    logic [2:0] kind;
  } pend_t;

  function automatic logic lt_signed(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                      input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    case (f3)
      3'd0: r = alt ? a - b : a + b;
      3'd1: r = a << b[4:0];
      3'd2: r = {31'd0, lt_signed(a, b)};
      3'd3: r = {31'd0, a < b};
      3'd4: r = a ^ b;
      3'd5: r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      3'd6: r = a | b;
      default: r = a & b;
    endcase
    return r;
  endfunction

  // register read addresses for an instruction word
  function automatic logic [9:0] src_addrs(input logic [31:0] w);
    logic [4:0] r1, r2;
    if (w[1:0] == 2'b11) begin
      r1 = w[19:15];
      r2 = w[24:20];
    end else if (w[1:0] == 2'b10) begin
      r1 = w[11:7];
      r2 = w[6:2];
    end else begin
      r1 = {2'b01, w[9:7]};
      r2 = {2'b01, w[4:2]};
    end
    return {r1, r2};
  endfunction

endpackage
`default_nettype wire

// ===== src/rvex_in_if.sv =====
`default_nettype none
interface rvex_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] instruction;
  logic [31:0] load_data;
  modport source (output valid, command, instruction, load_data, input ready);
  modport sink (input valid, command, instruction, load_data, output ready);
endinterface
`default_nettype wire

// ===== src/rvex_out_if.sv =====
`default_nettype none
interface rvex_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic [1:0]  mem_op;
  logic [31:0] mem_addr;
  logic [31:0] mem_wdata;
  logic [1:0]  mem_size;
  logic        wb_valid;
  logic [4:0]  wb_index;
  logic [31:0] wb_value;
  logic        trap;
  logic [1:0]  env_call;
  modport source (output valid, next_pc, mem_op, mem_addr, mem_wdata, mem_size, wb_valid,
                  wb_index, wb_value, trap, env_call, input ready);
  modport sink (input valid, next_pc, mem_op, mem_addr, mem_wdata, mem_size, wb_valid,
                wb_index, wb_value, trap, env_call, output ready);
endinterface
`default_nettype wire

// ===== src/rvex_cfg_if.sv =====
`default_nettype none
interface rvex_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== src/rvex_ram.sv =====
`default_nettype none
module rvex_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end
endmodule
`default_nettype wire

// ===== src/rvex_exec.sv =====
`default_nettype none
module rvex_exec (
  input  wire logic               command_i,
  input  wire logic [31:0]        instr_i,
  input  wire logic [31:0]        load_data_i,
  input  wire logic [31:0]        rs1_i,
  input  wire logic [31:0]        rs2_i,
  input  wire logic [31:0]        pc_i,
  input  wire rvex_pkg::pend_t    pend_i,
  output rvex_pkg::pend_t         pend_o,
  output rvex_pkg::result_t       res_o
);
  import rvex_pkg::*;

  logic [31:0] w, a, b, iimm, simm, bimm, jimm, npc, v, r;
  logic [6:0]  f7, off;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic        ok, take, do_wb;
  result_t     res;

  always_comb begin
    w    = instr_i;
    a    = rs1_i;
    b    = rs2_i;
    f7   = w[31:25];
    f3   = w[14:12];
    rd   = w[11:7];
    iimm = {{20{w[31]}}, w[31:20]};
    simm = {{20{w[31]}}, w[31:25], w[11:7]};
    bimm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    jimm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    off  = {w[5], w[12:10], w[6], 2'b00};
    res  = '0;
    pend_o = pend_i;
    ok    = 1'b1;
    take  = 1'b0;
    do_wb = 1'b0;
    v     = '0;
    r     = '0;
    npc   = pc_i;
    if (command_i == CMD_LOAD) begin
      if (pend_i.valid) begin
        case (pend_i.kind)
          LD_B:    v = {{24{load_data_i[7]}}, load_data_i[7:0]};
          LD_H:    v = {{16{load_data_i[15]}}, load_data_i[15:0]};
          LD_BU:   v = {24'd0, load_data_i[7:0]};
          LD_HU:   v = {16'd0, load_data_i[15:0]};
          default: v = load_data_i;
        endcase
        do_wb = 1'b1;
        rd    = pend_i.dest;
        pend_o.valid = 1'b0;
      end
    end else begin
      pend_o.valid = 1'b0;
      if (w[1:0] == 2'b11) begin
        npc = pc_i + 32'd4;
        case (w[6:0])
          OPC_LUI: begin
            do_wb = 1'b1; v = {w[31:12], 12'd0};
          end
          OPC_AUIPC: begin
            do_wb = 1'b1; v = pc_i + {w[31:12], 12'd0};
          end
          OPC_JAL: begin
            npc = pc_i + jimm; do_wb = 1'b1; v = pc_i + 32'd4;
          end
          OPC_JALR: begin
            if (f3 != 3'd0) begin
              ok = 1'b0;
            end else begin
              r = a + iimm;
              npc = {r[31:1], 1'b0}; do_wb = 1'b1; v = pc_i + 32'd4;
            end
          end
          OPC_BRANCH: begin
            case (f3)
              3'd0: take = a == b;
              3'd1: take = a != b;
              3'd4: take = lt_signed(a, b);
              3'd5: take = !lt_signed(a, b);
              3'd6: take = a < b;
              3'd7: take = a >= b;
              default: ok = 1'b0;
            endcase
            if (take) begin
              npc = pc_i + bimm;
            end
          end
          OPC_LOAD: begin
            if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
              ok = 1'b0;
            end else begin
              res.mem_op   = MEM_LOAD;
              res.mem_addr = a + iimm;
              res.mem_size = {1'b0, f3[1:0]} == 3'd0 ? SIZE_BYTE :
                             (f3[1:0] == 2'd1 ? SIZE_HALF : SIZE_WORD);
              pend_o.valid = 1'b1;
              pend_o.dest  = rd;
              pend_o.kind  = f3;
            end
          end
          OPC_STORE: begin
            if (f3 > 3'd2) begin
              ok = 1'b0;
            end else begin
              res.mem_op   = MEM_STORE;
              res.mem_addr = a + simm;
              res.mem_wdata = f3 == 3'd0 ? {24'd0, b[7:0]} :
                              (f3 == 3'd1 ? {16'd0, b[15:0]} : b);
              res.mem_size = f3[1:0];
            end
          end
          OPC_OPIMM: begin
            if (f3 == 3'd1 && f7 != F7_ZERO) begin
              ok = 1'b0;
            end else if (f3 == 3'd5) begin
              if (f7 != F7_ZERO && f7 != F7_ALT) begin
                ok = 1'b0;
              end else begin
                do_wb = 1'b1; v = alu(3'd5, f7 == F7_ALT, a, {27'd0, iimm[4:0]});
              end
            end else begin
              do_wb = 1'b1; v = alu(f3, 1'b0, a, iimm);
            end
          end
          OPC_OP: begin
            if (f7 != F7_ZERO && !(f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
              ok = 1'b0;
            end else begin
              do_wb = 1'b1; v = alu(f3, f7 == F7_ALT, a, b);
            end
          end
          OPC_SYSTEM: begin
            if (w == WORD_ECALL) begin
              res.env_call = ENV_ECALL;
            end else if (w == WORD_EBREAK) begin
              res.env_call = ENV_EBREAK;
            end else begin
              ok = 1'b0;
            end
          end
          default: ok = 1'b0;
        endcase
      end else begin
        npc = pc_i + 32'd2;
        if (w[1:0] == 2'b00 && w[15:13] == 3'd6) begin
          // c.sw
          res.mem_op    = MEM_STORE;
          res.mem_addr  = a + {25'd0, off};
          res.mem_wdata = b;
          res.mem_size  = SIZE_WORD;
        end else if (w[1:0] == 2'b01 && w[15:13] == 3'd4 && w[12:10] == 3'd3) begin
          rd = {2'b01, w[9:7]};
          do_wb = 1'b1;
          case (w[6:5])
            2'd0:    v = a - b;
            2'd1:    v = a ^ b;
            2'd2:    v = a | b;
            default: v = a & b;
          endcase
        end else if (w[1:0] == 2'b10 && w[6:2] != 5'd0 && w[15:12] == 4'd8) begin
          do_wb = 1'b1; v = b;
        end else if (w[1:0] == 2'b10 && w[6:2] != 5'd0 && w[15:12] == 4'd9) begin
          do_wb = 1'b1; v = a + b;
        end else begin
          ok = 1'b0;
        end
      end
    end
    if (do_wb && rd != 5'd0) begin
      res.wb_valid = 1'b1;
      res.wb_index = rd;
      res.wb_value = v;
    end
    if (!ok) begin
      res = '0;
      res.trap = 1'b1;
      pend_o.valid = 1'b0;
    end
    res.next_pc = npc;
    res_o = res;
  end
endmodule
`default_nettype wire

// ===== src/rv32i_execute_unit_top.sv =====
// pipeline: the input stage registers an accepted request, the result stage its result
// throughput: one request per cycle while the result register is free or draining;
// each request reads two registers and writes at most one
// register file reads use a registered ram read taken at accept, with bypass of the write
// reset: x1..x31 read as zero through per-entry valid bits, pc is zero, no load pending
// a reset_pc write loads the pc at once
`default_nettype none
module rv32i_execute_unit_top (
  input wire logic clk_i,
  input wire logic rst_ni,
  rvex_in_if.sink    in_i,
  rvex_out_if.source out_o,
  rvex_cfg_if.sink   cfg_i
);
  import rvex_pkg::*;

  // input stage
  logic        in_valid_q;
  logic        cmd_q;
  logic [31:0] instr_q, ld_q;
  logic [REG_AW-1:0] ra1_q, ra2_q;
  logic        byp1_q, byp2_q, vld1_q, vld2_q;
  logic [31:0] bypv1_q, bypv2_q;

  // architectural state
  logic [31:0]          pc_q;
  pend_t                pend_q, pend_d;
  logic [REG_COUNT-1:0] vld_q;

  // result stage
  logic    out_valid_q;
  result_t res_q, res_d;

  logic        fire, accept;
  logic [9:0]  ra;
  logic [31:0] ram1, ram2, rs1, rs2;

  // execute fires when the result register is free or being drained
  assign fire   = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || fire;
  assign accept = in_i.valid && in_i.ready;
  assign ra     = src_addrs(in_i.instruction);
  assign cfg_i.ready = 1'b1;

  rvex_ram #(.Width(XLEN), .Depth(REG_COUNT)) u_regs (
    .clk_i,
    .we_i      (fire && res_d.wb_valid),
    .waddr_i   (res_d.wb_index),
    .wdata_i   (res_d.wb_value),
    .re_i      (accept),
    .raddr_a_i (ra[9:5]),
    .raddr_b_i (ra[4:0]),
    .rdata_a_o (ram1),
    .rdata_b_o (ram2)
  );

  // x0 reads zero, never-written entries read zero, same-cycle writes bypass
  assign rs1 = (ra1_q == '0) ? '0 : byp1_q ? bypv1_q : vld1_q ? ram1 : '0;
  assign rs2 = (ra2_q == '0) ? '0 : byp2_q ? bypv2_q : vld2_q ? ram2 : '0;

  rvex_exec u_exec (
    .command_i   (cmd_q),
    .instr_i     (instr_q),
    .load_data_i (ld_q),
    .rs1_i       (rs1),
    .rs2_i       (rs2),
    .pc_i        (pc_q),
    .pend_i      (pend_q),
    .pend_o      (pend_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= in_i.command;
      instr_q <= in_i.instruction;
      ld_q    <= in_i.load_data;
      ra1_q   <= ra[9:5];
      ra2_q   <= ra[4:0];
      vld1_q  <= vld_q[ra[9:5]];
      vld2_q  <= vld_q[ra[4:0]];
      byp1_q  <= fire && res_d.wb_valid && res_d.wb_index == ra[9:5];
      byp2_q  <= fire && res_d.wb_valid && res_d.wb_index == ra[4:0];
      bypv1_q <= res_d.wb_value;
      bypv2_q <= res_d.wb_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      pend_q <= '0;
      vld_q  <= '0;
    end else begin
      if (cfg_i.valid) begin
        pc_q <= cfg_i.data;
      end else if (fire) begin
        pc_q <= res_d.next_pc;
      end
      if (fire) begin
        pend_q <= pend_d;
        if (res_d.wb_valid) begin
          vld_q[res_d.wb_index] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.next_pc   = res_q.next_pc;
  assign out_o.mem_op    = res_q.mem_op;
  assign out_o.mem_addr  = res_q.mem_addr;
  assign out_o.mem_wdata = res_q.mem_wdata;
  assign out_o.mem_size  = res_q.mem_size;
  assign out_o.wb_valid  = res_q.wb_valid;
  assign out_o.wb_index  = res_q.wb_index;
  assign out_o.wb_value  = res_q.wb_value;
  assign out_o.trap      = res_q.trap;
  assign out_o.env_call  = res_q.env_call;

`ifndef ASSERT_OFF
  a_wb_not_x0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.wb_valid |-> res_q.wb_index != 5'd0)
    else $error("write-back to x0");
  a_trap_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.trap |-> res_q.mem_op == MEM_NONE && !res_q.wb_valid)
    else $error("trap with side effect");
  a_hold_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q)
    else $error("stalled request lost");
  a_load_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_d.mem_op == MEM_LOAD |=> pend_q.valid)
    else $error("load issued without pending state");
`endif
endmodule
`default_nettype wire

// ===== sim/tb_rv32i_execute_unit_if.sv =====
`timescale 1ns / 100ps
// the interfaces live with the rtl; only the field code package is declared here
package tb_rvex_codes_pkg;
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] BR_EQ   = 3'd0;
  localparam logic [2:0] BR_NE   = 3'd1;
  localparam logic [2:0] BR_LT   = 3'd4;
  localparam logic [2:0] BR_GE   = 3'd5;
  localparam logic [2:0] BR_LTU  = 3'd6;
  localparam logic [2:0] BR_GEU  = 3'd7;
  localparam logic [2:0] LD_W    = 3'd2;
endpackage

// ===== sim/tb_rv32i_execute_unit_top.sv =====
`timescale 1ns / 100ps
module tb_rv32i_execute_unit_top;
  import rvex_pkg::*;
  import tb_rvex_codes_pkg::*;

  typedef struct {
    logic        cfg;      // reset_pc write instead of a request
    logic        command;
    logic [31:0] instruction;
    logic [31:0] load_data;
  } req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  rvex_in_if  in_if ();
  rvex_out_if out_if ();
  rvex_cfg_if cfg_if ();

  rv32i_execute_unit_top i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  // predictor state, mirrors the core's architectural state
  logic [31:0] arch_regs [32];
  logic [31:0] arch_pc;
  logic        ld_pend;
  logic [4:0]  ld_dest;
  logic [2:0]  ld_kind;

  req_t    pending_reqs[$];
  result_t expected_results[$];
  int      errors = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  logic    hold_off = 1'b0;
  int      quiet_cycles = 0;
  logic    in_fire_q = 1'b0;
  logic    cfg_fire_q = 1'b0;

  function automatic logic [31:0] sx(input logic [31:0] v, input int bits);
    logic [31:0] m;
    m = 32'd1 << (bits - 1);
    v = v & ((m << 1) - 1);
    return (v ^ m) - m;
  endfunction

  function automatic logic [31:0] calc(input logic [2:0] f3, input logic alt,
                                       input logic [31:0] a, input logic [31:0] b);
    case (f3)
      F3_ADD:  return alt ? a - b : a + b;
      F3_SLL:  return a << b[4:0];
      F3_SLT:  return {31'd0, $signed(a) < $signed(b)};
      F3_SLTU: return {31'd0, a < b};
      F3_XOR:  return a ^ b;
      F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  function automatic void write_reg(inout result_t r, input logic [4:0] rd,
                                    input logic [31:0] v);
    if (rd == 5'd0) return;
    arch_regs[rd] = v;
    r.wb_valid = 1'b1;
    r.wb_index = rd;
    r.wb_value = v;
  endfunction

  // 16-bit subset; returns 0 when the encoding traps
  function automatic logic exec_compressed(input logic [15:0] w, inout result_t r);
    logic [4:0]  rdp, rs2p, rd, rs2;
    logic [31:0] a, b, off;
    rdp  = {2'b01, w[9:7]};
    rs2p = {2'b01, w[4:2]};
    if (w[1:0] == 2'b00 && w[15:13] == 3'd6) begin
      off = {25'd0, w[5], w[12:10], w[6], 2'b00};
      r.mem_op    = MEM_STORE;
      r.mem_addr  = arch_regs[rdp] + off;
      r.mem_wdata = arch_regs[rs2p];
      r.mem_size  = SIZE_WORD;
      return 1'b1;
    end
    if (w[1:0] == 2'b01 && w[15:13] == 3'd4 && w[12:10] == 3'd3) begin
      a = arch_regs[rdp];
      b = arch_regs[rs2p];
      case (w[6:5])
        2'd0: write_reg(r, rdp, a - b);
        2'd1: write_reg(r, rdp, a ^ b);
        2'd2: write_reg(r, rdp, a | b);
        default: write_reg(r, rdp, a & b);
      endcase
      return 1'b1;
    end
    if (w[1:0] == 2'b10) begin
      rd  = w[11:7];
      rs2 = w[6:2];
      if (rs2 == 5'd0) return 1'b0;
      if (w[15:12] == 4'h8) begin write_reg(r, rd, arch_regs[rs2]); return 1'b1; end
      if (w[15:12] == 4'h9) begin
        write_reg(r, rd, arch_regs[rd] + arch_regs[rs2]);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic exec_word(input logic [31:0] w, inout logic [31:0] npc,
                                     inout result_t r);
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] a, b, iimm, simm, bimm, jimm, link;
    logic        take;
    f7 = w[31:25];
    f3 = w[14:12];
    rd = w[11:7];
    a = arch_regs[w[19:15]];
    b = arch_regs[w[24:20]];
    iimm = sx({20'd0, w[31:20]}, 12);
    simm = sx({20'd0, w[31:25], w[11:7]}, 12);
    bimm = sx({19'd0, w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
    jimm = sx({11'd0, w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
    link = arch_pc + 32'd4;
    case (w[6:0])
      OPC_LUI:   begin write_reg(r, rd, {w[31:12], 12'd0}); return 1'b1; end
      OPC_AUIPC: begin write_reg(r, rd, arch_pc + {w[31:12], 12'd0}); return 1'b1; end
      OPC_JAL:   begin npc = arch_pc + jimm; write_reg(r, rd, link); return 1'b1; end
      OPC_JALR: begin
        if (f3 != 3'd0) return 1'b0;
        npc = (a + iimm) & ~32'd1;
        write_reg(r, rd, link);
        return 1'b1;
      end
      OPC_BRANCH: begin
        case (f3)
          BR_EQ:  take = a == b;
          BR_NE:  take = a != b;
          BR_LT:  take = $signed(a) < $signed(b);
          BR_GE:  take = !($signed(a) < $signed(b));
          BR_LTU: take = a < b;
          BR_GEU: take = a >= b;
          default: return 1'b0;
        endcase
        if (take) npc = arch_pc + bimm;
        return 1'b1;
      end
      OPC_LOAD: begin
        if (f3 == 3'd3 || f3 > LD_HU) return 1'b0;
        r.mem_op   = MEM_LOAD;
        r.mem_addr = a + iimm;
        r.mem_size = f3[1:0];
        ld_pend = 1'b1;
        ld_dest = rd;
        ld_kind = f3;
        return 1'b1;
      end
      OPC_STORE: begin
        if (f3 > 3'd2) return 1'b0;
        r.mem_op    = MEM_STORE;
        r.mem_addr  = a + simm;
        r.mem_wdata = f3 == 3'd0 ? (b & 32'hFF) : f3 == 3'd1 ? (b & 32'hFFFF) : b;
        r.mem_size  = f3[1:0];
        return 1'b1;
      end
      OPC_OPIMM: begin
        if (f3 == F3_SLL && f7 != F7_ZERO) return 1'b0;
        if (f3 == F3_SR) begin
          if (f7 != F7_ZERO && f7 != F7_ALT) return 1'b0;
          write_reg(r, rd, calc(F3_SR, f7 == F7_ALT, a, iimm & 32'h1F));
          return 1'b1;
        end
        write_reg(r, rd, calc(f3, 1'b0, a, iimm));
        return 1'b1;
      end
      OPC_OP: begin
        if (f7 != F7_ZERO && !(f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR)))
          return 1'b0;
        write_reg(r, rd, calc(f3, f7 == F7_ALT, a, b));
        return 1'b1;
      end
      OPC_SYSTEM: begin
        if (w == WORD_ECALL) begin r.env_call = ENV_ECALL; return 1'b1; end
        if (w == WORD_EBREAK) begin r.env_call = ENV_EBREAK; return 1'b1; end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic result_t execute_request(input req_t q);
    result_t     r;
    logic [31:0] v, npc;
    logic [31:0] saved [32];
    logic        ok;
    r = '0;
    if (q.command == CMD_LOAD) begin
      if (ld_pend) begin
        case (ld_kind)
          LD_B:  v = sx(q.load_data, 8);
          LD_H:  v = sx(q.load_data, 16);
          LD_BU: v = q.load_data & 32'hFF;
          LD_HU: v = q.load_data & 32'hFFFF;
          default: v = q.load_data;
        endcase
        write_reg(r, ld_dest, v);
        ld_pend = 1'b0;
      end
      r.next_pc = arch_pc;
      return r;
    end
    ld_pend = 1'b0;
    saved = arch_regs;
    if (q.instruction[1:0] == 2'b11) begin
      npc = arch_pc + 32'd4;
      ok = exec_word(q.instruction, npc, r);
    end else begin
      npc = arch_pc + 32'd2;
      ok = exec_compressed(q.instruction[15:0], r);
    end
    if (!ok) begin
      r = '0;
      r.trap = 1'b1;
      arch_regs = saved;
      ld_pend = 1'b0;
    end
    arch_pc = npc;
    r.next_pc = arch_pc;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic void push_exec(input logic [31:0] w);
    req_t q;
    q = '{1'b0, CMD_EXEC, w, $urandom()};
    pending_reqs.push_back(q);
  endfunction

  function automatic void push_load_data(input logic [31:0] d);
    req_t q;
    q = '{1'b0, CMD_LOAD, $urandom(), d};
    pending_reqs.push_back(q);
  endfunction

  function automatic void push_cfg(input logic [31:0] pc);
    req_t q;
    q = '{1'b1, CMD_EXEC, pc, 32'd0};
    pending_reqs.push_back(q);
  endfunction

  function automatic logic [4:0] rreg();
    // bias toward a small register window so values get reused
    return ($urandom_range(0, 3) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 11));
  endfunction

  function automatic logic [31:0] r_type(input logic [6:0] f7, input logic [2:0] f3,
                                         input logic [6:0] opc);
    return {f7, rreg(), rreg(), f3, rreg(), opc};
  endfunction

  // mostly well-formed words with random fields, some raw noise
  function automatic logic [31:0] random_instr();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 15))
      0: w[6:0] = OPC_LUI;
      1: w[6:0] = OPC_AUIPC;
      2: w[6:0] = OPC_JAL;
      3: begin w[6:0] = OPC_JALR; if ($urandom_range(0, 3) != 0) w[14:12] = 3'd0; end
      4: w = {w[31:25], rreg(), rreg(), w[14:12], w[11:7], OPC_BRANCH};
      5: w = {w[31:20], rreg(), w[14:12], rreg(), OPC_LOAD};
      6: w = {w[31:25], rreg(), rreg(), 1'b0, w[13:12], w[11:7], OPC_STORE};
      7: begin
        w = {w[31:20], rreg(), w[14:12], rreg(), OPC_OPIMM};
        if ($urandom_range(0, 3) != 0) w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_ZERO;
      end
      8, 9: w = r_type($urandom_range(0, 5) != 0 ? ($urandom_range(0, 1) ? F7_ALT : F7_ZERO)
                                             : 7'($urandom()), 3'($urandom()), OPC_OP);
      10: w = ($urandom_range(0, 2) == 0) ? WORD_ECALL
             : ($urandom_range(0, 1) ? WORD_EBREAK : {w[31:7], OPC_SYSTEM});
      11: w = {16'($urandom()), 3'd6, w[12:2], 2'b00};
      12: w = {16'($urandom()), 3'd4, 3'd3, w[9:2], 2'b01};
      13: w = {16'($urandom()), 3'd4, 1'($urandom()), rreg(), rreg(), 2'b10};
      default: ;
    endcase
    return w;
  endfunction

  task automatic fill_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) push_load_data($urandom());
      else push_exec(random_instr());
    end
  endtask

  // load-use pairs, register seeding and a few stray returns
  task automatic fill_directed();
    push_exec({20'hFFFFF, 5'd1, OPC_LUI});                       // x1 = 0xfffff000
    push_exec({12'h7FF, 5'd1, F3_OR, 5'd2, OPC_OPIMM});           // x2 = x1 | 0x7ff
    push_exec({12'hFFF, 5'd0, F3_ADD, 5'd3, OPC_OPIMM});          // x3 = -1
    push_exec({12'h7FF, 5'd0, F3_ADD, 5'd4, OPC_OPIMM});          // x4 = 2047
    push_exec(r_type(F7_ZERO, F3_SLT, OPC_OP));
    push_exec({F7_ZERO, 5'd4, 5'd3, F3_SLT, 5'd5, OPC_OP});       // signed compare
    push_exec({F7_ZERO, 5'd4, 5'd3, F3_SLTU, 5'd6, OPC_OP});      // unsigned compare
    push_exec({F7_ALT, 5'd31, 5'd3, F3_SR, 5'd7, OPC_OPIMM});     // srai by 31
    push_exec({F7_ZERO, 5'd4, 5'd3, F3_ADD, 5'd0, OPC_OP});       // dest x0 discarded
    push_exec({12'h004, 5'd3, LD_B, 5'd8, OPC_LOAD});
    push_load_data(32'h0000_0080);                                // lb sign extension
    push_exec({12'h000, 5'd3, LD_HU, 5'd9, OPC_LOAD});
    push_load_data(32'hFFFF_8001);
    push_exec({12'h000, 5'd3, LD_W, 5'd10, OPC_LOAD});
    push_exec(WORD_ECALL);                                        // drops the pending load
    push_load_data(32'hDEAD_BEEF);                                // no load pending
    push_exec(WORD_EBREAK);
    push_exec({7'h40, 5'd3, 5'd4, BR_LT, 5'd1, OPC_BRANCH});      // backward, not taken
    push_exec({7'h00, 5'd3, 5'd3, BR_GEU, 5'd8, OPC_BRANCH});     // taken forward
    push_exec({7'h7F, 5'd2, 5'd1, 3'd2, 5'd8, OPC_STORE});        // sw, negative offset
    push_exec({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd1, OPC_JAL});
    push_exec({12'hFFF, 5'd3, 3'd0, 5'd2, OPC_JALR});
    push_exec(32'h0000_0000);                                     // compressed all zero
    push_exec({16'd0, 4'h8, 5'd11, 5'd0, 2'b10});                 // c.mv with rs2 zero
    push_exec(32'hFFFF_FFFF);                                     // reserved opcode
  endtask

  // ------------------------------------------------------------ accept tracking
  // predictor runs at the accepting edge, in request order
  always @(posedge clk_i) begin
    req_t q;
    in_fire_q  <= rst_ni && in_if.valid && in_if.ready;
    cfg_fire_q <= rst_ni && cfg_if.valid && cfg_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      q = '{1'b0, in_if.command, in_if.instruction, in_if.load_data};
      expected_results.push_back(execute_request(q));
    end
    if (rst_ni && cfg_if.valid && cfg_if.ready) arch_pc = cfg_if.data;
  end

  // ------------------------------------------------------------ driver
  always @(negedge clk_i) begin
    req_t q;
    if (rst_ni) begin
      if (in_if.valid && in_fire_q) in_if.valid = 1'b0;
      if (cfg_if.valid && cfg_fire_q) cfg_if.valid = 1'b0;
      if (!in_if.valid && !cfg_if.valid && pending_reqs.size() != 0) begin
        if (pending_reqs[0].cfg) begin
          // register write only when the core is idle
          if (expected_results.size() == 0) begin
            q = pending_reqs.pop_front();
            cfg_if.data  = q.instruction;
            cfg_if.valid = 1'b1;
          end
        end else if ($urandom_range(1, 100) > send_idle_pct) begin
          q = pending_reqs.pop_front();
          in_if.command     = q.command;
          in_if.instruction = q.instruction;
          in_if.load_data   = q.load_data;
          in_if.valid       = 1'b1;
        end
      end
    end
  end

  // ------------------------------------------------------------ monitor
  always @(posedge clk_i) begin
    result_t got, exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.next_pc, out_if.mem_op, out_if.mem_addr, out_if.mem_wdata,
              out_if.mem_size, out_if.wb_valid, out_if.wb_index, out_if.wb_value,
              out_if.trap, out_if.env_call};
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: next_pc %h", got.next_pc);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.next_pc !== exp_r.next_pc) begin
          $error("next_pc exp %h got %h", exp_r.next_pc, got.next_pc); errors++; end
        if (got.mem_op !== exp_r.mem_op) begin
          $error("mem_op exp %h got %h", exp_r.mem_op, got.mem_op); errors++; end
        if (got.mem_addr !== exp_r.mem_addr) begin
          $error("mem_addr exp %h got %h", exp_r.mem_addr, got.mem_addr); errors++; end
        if (got.mem_wdata !== exp_r.mem_wdata) begin
          $error("mem_wdata exp %h got %h", exp_r.mem_wdata, got.mem_wdata); errors++; end
        if (got.mem_size !== exp_r.mem_size) begin
          $error("mem_size exp %h got %h", exp_r.mem_size, got.mem_size); errors++; end
        if (got.wb_valid !== exp_r.wb_valid) begin
          $error("wb_valid exp %h got %h", exp_r.wb_valid, got.wb_valid); errors++; end
        if (got.wb_index !== exp_r.wb_index) begin
          $error("wb_index exp %h got %h", exp_r.wb_index, got.wb_index); errors++; end
        if (got.wb_value !== exp_r.wb_value) begin
          $error("wb_value exp %h got %h", exp_r.wb_value, got.wb_value); errors++; end
        if (got.trap !== exp_r.trap) begin
          $error("trap exp %h got %h", exp_r.trap, got.trap); errors++; end
        if (got.env_call !== exp_r.env_call) begin
          $error("env_call exp %h got %h", exp_r.env_call, got.env_call); errors++; end
      end
    end
  end

  // receiver backpressure, with a long hold-off on request
  always @(negedge clk_i) begin
    out_if.ready <= !hold_off && ($urandom_range(1, 100) > recv_stall_pct);
  end

  // watchdog on cycles with no accepted request, result or register write
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || hold_off)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_results.size() != 0 ||
           in_if.valid || cfg_if.valid) @(posedge clk_i);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.command = CMD_EXEC;
    in_if.instruction = '0;
    in_if.load_data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    arch_pc = '0;
    ld_pend = 1'b0;
    ld_dest = '0;
    ld_kind = '0;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed set with no idling, starting from the reset pc
    fill_directed();
    wait_drained();

    // phases: idle pattern and reset_pc setting change together
    push_cfg(32'hFFFF_FFF0);
    fill_random(300);
    wait_drained();
    send_idle_pct = 83;
    push_cfg(32'h0000_0000);
    fill_random(250);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 83;
    push_cfg(32'hFFFF_FFFF);
    fill_random(250);
    wait_drained();
    send_idle_pct = 31;
    recv_stall_pct = 31;
    push_cfg($urandom());
    fill_random(250);
    wait_drained();

    // long receiver hold-off while requests keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    push_cfg(32'h8000_0000);
    fill_random(250);
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
src/rvex_pkg.sv
src/rvex_in_if.sv
src/rvex_out_if.sv
src/rvex_cfg_if.sv
src/rvex_ram.sv
src/rvex_exec.sv
src/rv32i_execute_unit_top.sv
sim/tb_rv32i_execute_unit_if.sv
sim/tb_rv32i_execute_unit_top.sv
